>>> rtl/core/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath structs of the buddy block
// allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int POOL_ORDER_DEF = 16;
    localparam int MIN_ORDER_DEF  = 4;
    localparam int HDR_BYTES      = 8;
    localparam int ORDER_W        = 5;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] RES_ALLOCATED = 2'd0;
    localparam logic [1:0] RES_NO_SPACE  = 2'd1;
    localparam logic [1:0] RES_FREED     = 2'd2;
    localparam logic [1:0] RES_IGNORED   = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;
    localparam logic [3:0] CMD_DECODE  = 4'd2;
    localparam logic [3:0] CMD_A_TAKE  = 4'd3;
    localparam logic [3:0] CMD_A_SPLIT = 4'd4;
    localparam logic [3:0] CMD_F_CHECK = 4'd5;
    localparam logic [3:0] CMD_F_READ  = 4'd6;
    localparam logic [3:0] CMD_F_MERGE = 4'd7;
    localparam logic [3:0] CMD_F_FIN1  = 4'd8;
    localparam logic [3:0] CMD_F_FIN2  = 4'd9;

    typedef struct packed {
        logic [3:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic        op;          // latched opcode
        logic        alloc_fail;  // no order fits or no free block
        logic        free_bad;    // bad free address
        logic        order_bad;   // stored header invalid or already free
        logic        chk_more;    // stored order below pool order
        logic        can_merge;   // buddy free and of equal order
        logic        merge_more;  // another level above after this merge
        logic        split_more;  // taken block larger than wanted
        logic        split_last;  // this split reaches the wanted order
        logic [15:0] payload;     // block offset plus header
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/bba_dp.sv
// ---------------------------------------------------------------------------
// bba_dp
// Allocator datapath: block header memories, list heads and tails, order
// search, split and merge arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_dp
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = POOL_ORDER_DEF,
    parameter int MIN_ORDER  = MIN_ORDER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic        in_op,
    input  wire logic [15:0] in_request_bytes,
    input  wire logic [15:0] in_free_address,
    output dp_stat_t         st
);

    localparam int GBITS = POOL_ORDER - MIN_ORDER;
    localparam int IW    = (GBITS > 0) ? GBITS : 1;
    localparam int NBLK  = 1 << GBITS;
    localparam int NLIST = POOL_ORDER + 1;
    localparam int NW    = $clog2(NBLK + NLIST);
    localparam int LW    = $clog2(NLIST);

    function automatic logic [NW-1:0] sent(input logic [ORDER_W-1:0] j);
        sent = NW'(NBLK) + NW'(j);
    endfunction

    // header memories
    logic [ORDER_W-1:0] order_mem [NBLK];
    logic               free_mem  [NBLK];
    logic [NW-1:0]      next_mem  [NBLK];
    logic [NW-1:0]      prev_mem  [NBLK];

    logic [NW-1:0] lf_reg [NLIST];
    logic [NW-1:0] ll_reg [NLIST];
    logic [3:0]    w0_reg;   // entry 0 of order/free/next/prev written

    logic               op_reg;
    logic [15:0]        req_reg;
    logic [15:0]        addr_reg;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] j_reg, j_next;
    logic [IW-1:0]      l_reg, l_next;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [ORDER_W-1:0] rd_order_reg;
    logic               rd_free_reg;
    logic [NW-1:0]      rd_next_reg, rd_prev_reg;
    logic               rd0_reg;

    logic [ORDER_W-1:0] e_order;
    logic               e_free;
    logic [NW-1:0]      e_next, e_prev;

    // decode
    logic [16:0]        size;
    logic [ORDER_W-1:0] kc;
    logic               k_found;
    logic [ORDER_W-1:0] jf;
    logic               j_found;
    logic [NW-1:0]      l_head;
    logic [15:0]        off;
    logic [31:0]        g32;
    logic [IW-1:0]      buddy;
    logic [IW:0]        split_p;
    logic [ORDER_W-1:0] jn;
    logic [NW-1:0]      hd;
    logic [31:0]        pay32;

    // write requests
    logic               sn_en, sp_en;
    logic [NW-1:0]      sn_id, sn_val, sp_id, sp_val, sn_off, sp_off;
    logic               lfd_en, lld_en;
    logic [LW-1:0]      lfd_i, lld_i;
    logic [NW-1:0]      lfd_v, lld_v;
    logic               ord_we, fr_we;
    logic [IW-1:0]      ord_wa, fr_wa;
    logic [ORDER_W-1:0] ord_wd;
    logic               fr_wd;
    logic               next_we, prev_we, sn_sent, sp_sent;
    logic               lf_we, ll_we;
    logic [LW-1:0]      lf_wi, ll_wi;
    logic [NW-1:0]      lf_wd, ll_wd;

    // entry 0 reads its reset contents until first written
    assign e_order = (rd0_reg && !w0_reg[0]) ? ORDER_W'(POOL_ORDER) : rd_order_reg;
    assign e_free  = (rd0_reg && !w0_reg[1]) ? 1'b1 : rd_free_reg;
    assign e_next  = (rd0_reg && !w0_reg[2]) ? sent(ORDER_W'(POOL_ORDER)) : rd_next_reg;
    assign e_prev  = (rd0_reg && !w0_reg[3]) ? sent(ORDER_W'(POOL_ORDER)) : rd_prev_reg;

    always_comb begin
        size    = {1'b0, req_reg} + 17'(HDR_BYTES);
        kc      = '0;
        k_found = 1'b0;
        for (int k = POOL_ORDER; k >= MIN_ORDER; k--) begin
            if (26'(size) <= (26'd1 << k)) begin
                kc      = ORDER_W'(k);
                k_found = 1'b1;
            end
        end
        jf      = '0;
        j_found = 1'b0;
        for (int j = POOL_ORDER; j >= 0; j--) begin
            if ((ORDER_W'(j) >= kc) && (lf_reg[j] != sent(ORDER_W'(j)))) begin
                jf      = ORDER_W'(j);
                j_found = 1'b1;
            end
        end
    end

    assign l_head  = lf_reg[LW'(jf)];
    assign off     = addr_reg - 16'(HDR_BYTES);
    assign g32     = 32'(off) >> MIN_ORDER;
    assign buddy   = l_reg ^ (IW'(1) << (k_reg - ORDER_W'(MIN_ORDER)));
    assign jn      = j_reg - ORDER_W'(1);
    assign split_p = {1'b0, l_reg} + ((IW+1)'(1) << (jn - ORDER_W'(MIN_ORDER)));
    assign hd      = lf_reg[LW'(k_reg)];
    assign pay32   = (32'(l_reg) << MIN_ORDER) + 32'(HDR_BYTES);

    always_comb begin
        st            = '0;
        st.op         = op_reg;
        st.alloc_fail = !k_found || !j_found || (l_head >= NW'(NBLK));
        st.free_bad   = (addr_reg < 16'(HDR_BYTES))
                     || ((off & 16'((1 << MIN_ORDER) - 1)) != 16'd0)
                     || (g32 >= 32'(NBLK));
        st.order_bad  = (e_order < ORDER_W'(MIN_ORDER))
                     || (e_order > ORDER_W'(POOL_ORDER)) || e_free;
        st.chk_more   = e_order < ORDER_W'(POOL_ORDER);
        st.can_merge  = (e_order == k_reg) && e_free;
        st.merge_more = (k_reg + ORDER_W'(1)) < ORDER_W'(POOL_ORDER);
        st.split_more = j_reg != k_reg;
        st.split_last = j_reg == (k_reg + ORDER_W'(1));
        st.payload    = pay32[15:0];
    end

    always_comb begin
        k_next  = k_reg;
        j_next  = j_reg;
        l_next  = l_reg;
        rd_en   = 1'b0;
        rd_addr = l_reg;
        sn_en = 1'b0; sn_id = '0; sn_val = '0;
        sp_en = 1'b0; sp_id = '0; sp_val = '0;
        lfd_en = 1'b0; lfd_i = '0; lfd_v = '0;
        lld_en = 1'b0; lld_i = '0; lld_v = '0;
        ord_we = 1'b0; ord_wa = l_reg; ord_wd = k_reg;
        fr_we  = 1'b0; fr_wa  = l_reg; fr_wd  = 1'b0;
        unique case (cmd.code)
            CMD_DECODE: begin
                k_next  = kc;
                j_next  = jf;
                l_next  = (op_reg == OP_FREE) ? g32[IW-1:0] : l_head[IW-1:0];
                rd_en   = 1'b1;
                rd_addr = l_next;
            end
            CMD_A_TAKE: begin
                lfd_en = 1'b1; lfd_i = LW'(j_reg); lfd_v = e_next;
                sp_en  = 1'b1; sp_id = e_next; sp_val = sent(j_reg);
                ord_we = 1'b1;
                fr_we  = 1'b1; fr_wd = 1'b0;
            end
            CMD_A_SPLIT: begin
                j_next = jn;
                if (split_p < (IW+1)'(NBLK)) begin
                    fr_we  = 1'b1; fr_wa = split_p[IW-1:0]; fr_wd = 1'b1;
                    ord_we = 1'b1; ord_wa = split_p[IW-1:0]; ord_wd = jn;
                    sn_en  = 1'b1; sn_id = NW'(split_p); sn_val = sent(jn);
                    sp_en  = 1'b1; sp_id = NW'(split_p); sp_val = sent(jn);
                    lfd_en = 1'b1; lfd_i = LW'(jn); lfd_v = NW'(split_p);
                    lld_en = 1'b1; lld_i = LW'(jn); lld_v = NW'(split_p);
                end
            end
            CMD_F_CHECK: k_next = e_order;
            CMD_F_READ: begin
                rd_en   = 1'b1;
                rd_addr = buddy;
            end
            CMD_F_MERGE: begin
                if (st.can_merge) begin
                    // unlink the buddy and grow by one order
                    sn_en  = 1'b1; sn_id = e_prev; sn_val = e_next;
                    sp_en  = 1'b1; sp_id = e_next; sp_val = e_prev;
                    k_next = k_reg + ORDER_W'(1);
                    l_next = (buddy < l_reg) ? buddy : l_reg;
                end
            end
            CMD_F_FIN1: begin
                fr_we  = 1'b1; fr_wd = 1'b1;
                ord_we = 1'b1;
                sn_en  = 1'b1; sn_id = NW'(l_reg); sn_val = hd;
                sp_en  = 1'b1; sp_id = hd; sp_val = NW'(l_reg);
            end
            CMD_F_FIN2: begin
                sp_en  = 1'b1; sp_id = NW'(l_reg); sp_val = sent(k_reg);
                lfd_en = 1'b1; lfd_i = LW'(k_reg); lfd_v = NW'(l_reg);
            end
            default: ;
        endcase
    end

    // route node writes to block memories or list sentinels
    assign sn_off  = sn_id - NW'(NBLK);
    assign sp_off  = sp_id - NW'(NBLK);
    assign next_we = sn_en && (sn_id < NW'(NBLK));
    assign prev_we = sp_en && (sp_id < NW'(NBLK));
    assign sn_sent = sn_en && (sn_id >= NW'(NBLK)) && (sn_off < NW'(NLIST));
    assign sp_sent = sp_en && (sp_id >= NW'(NBLK)) && (sp_off < NW'(NLIST));
    assign lf_we   = lfd_en || sn_sent;
    assign lf_wi   = lfd_en ? lfd_i : sn_off[LW-1:0];
    assign lf_wd   = lfd_en ? lfd_v : sn_val;
    assign ll_we   = lld_en || sp_sent;
    assign ll_wi   = lld_en ? lld_i : sp_off[LW-1:0];
    assign ll_wd   = lld_en ? lld_v : sp_val;

    always_ff @(posedge aclk) begin
        if (ord_we)  order_mem[ord_wa] <= ord_wd;
        if (fr_we)   free_mem[fr_wa]   <= fr_wd;
        if (next_we) next_mem[sn_id[IW-1:0]] <= sn_val;
        if (prev_we) prev_mem[sp_id[IW-1:0]] <= sp_val;
        if (rd_en) begin
            rd_order_reg <= order_mem[rd_addr];
            rd_free_reg  <= free_mem[rd_addr];
            rd_next_reg  <= next_mem[rd_addr];
            rd_prev_reg  <= prev_mem[rd_addr];
            rd0_reg      <= rd_addr == '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.code == CMD_LOAD) begin
            op_reg   <= in_op;
            req_reg  <= in_request_bytes;
            addr_reg <= in_free_address;
        end
        k_reg <= k_next;
        j_reg <= j_next;
        l_reg <= l_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NLIST; j++) begin
                lf_reg[j] <= (j == POOL_ORDER) ? '0 : sent(ORDER_W'(j));
                ll_reg[j] <= (j == POOL_ORDER) ? '0 : sent(ORDER_W'(j));
            end
            w0_reg <= '0;
        end else begin
            if (lf_we) lf_reg[lf_wi] <= lf_wd;
            if (ll_we) ll_reg[ll_wi] <= ll_wd;
            if (ord_we  && ord_wa == '0)          w0_reg[0] <= 1'b1;
            if (fr_we   && fr_wa == '0)           w0_reg[1] <= 1'b1;
            if (next_we && sn_id[IW-1:0] == '0)   w0_reg[2] <= 1'b1;
            if (prev_we && sp_id[IW-1:0] == '0)   w0_reg[3] <= 1'b1;
        end
    end

    a_split_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.code == CMD_A_SPLIT) |-> (j_reg > k_reg))
        else $error("split below the wanted order");

    a_merge_below_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.code == CMD_F_READ) |-> (k_reg < ORDER_W'(POOL_ORDER)))
        else $error("buddy read at pool order");

endmodule

`default_nettype wire

>>> rtl/core/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// Allocator controller: sequences decode, split and merge steps and holds
// the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_payload_address,
    output dp_cmd_t          cmd,
    input  wire dp_stat_t    st
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_A_TAKE  = 4'd2;
    localparam logic [3:0] S_A_SPLIT = 4'd3;
    localparam logic [3:0] S_F_CHECK = 4'd4;
    localparam logic [3:0] S_F_READ  = 4'd5;
    localparam logic [3:0] S_F_MERGE = 4'd6;
    localparam logic [3:0] S_F_FIN1  = 4'd7;
    localparam logic [3:0] S_F_FIN2  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  res_reg, res_next;
    logic        mv_reg, mv_next;
    logic [1:0]  ms_reg, ms_next;
    logic [15:0] ma_reg, ma_next;
    logic        slot_free;

    assign s_tready          = state_reg == S_IDLE;
    assign m_tvalid          = mv_reg;
    assign m_status          = ms_reg;
    assign m_payload_address = ma_reg;
    assign slot_free         = !mv_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.code   = CMD_NONE;
        mv_next    = mv_reg && !m_tready;
        ms_next    = ms_reg;
        ma_next    = ma_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.code   = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.code = CMD_DECODE;
                if (st.op == OP_ALLOC) begin
                    if (st.alloc_fail) begin
                        res_next   = RES_NO_SPACE;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_A_TAKE;
                    end
                end else if (st.free_bad) begin
                    res_next   = RES_IGNORED;
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_CHECK;
                end
            end
            S_A_TAKE: begin
                cmd.code = CMD_A_TAKE;
                res_next = RES_ALLOCATED;
                state_next = st.split_more ? S_A_SPLIT : S_DONE;
            end
            S_A_SPLIT: begin
                cmd.code = CMD_A_SPLIT;
                if (st.split_last) state_next = S_DONE;
            end
            S_F_CHECK: begin
                cmd.code = CMD_F_CHECK;
                if (st.order_bad) begin
                    res_next   = RES_IGNORED;
                    state_next = S_DONE;
                end else begin
                    state_next = st.chk_more ? S_F_READ : S_F_FIN1;
                end
            end
            S_F_READ: begin
                cmd.code   = CMD_F_READ;
                state_next = S_F_MERGE;
            end
            S_F_MERGE: begin
                cmd.code   = CMD_F_MERGE;
                state_next = (st.can_merge && st.merge_more) ? S_F_READ : S_F_FIN1;
            end
            S_F_FIN1: begin
                cmd.code   = CMD_F_FIN1;
                state_next = S_F_FIN2;
            end
            S_F_FIN2: begin
                cmd.code   = CMD_F_FIN2;
                res_next   = RES_FREED;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (slot_free) begin
                    mv_next    = 1'b1;
                    ms_next    = res_reg;
                    ma_next    = (res_reg == RES_ALLOCATED) ? st.payload : 16'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        res_reg <= res_next;
        ms_reg  <= ms_next;
        ma_reg  <= ma_next;
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");

    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && slot_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not presented");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_status != RES_ALLOCATED) |-> (m_payload_address == 16'd0))
        else $error("address on a non-allocation result");

endmodule

`default_nettype wire

>>> rtl/core/buddy_block_allocator.sv
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a 2^POOL_ORDER byte pool with one doubly
// linked free list per order.
// ---------------------------------------------------------------------------
//  Channel | Dir | tuser       | tdata (low bit first)
//  s_      | in  | op          | request_bytes[15:0], free_address[31:16]
//  m_      | out | status[1:0] | payload_address[15:0]
//
//  One beat in flight. Allocate: decode, take, one split per split level;
//  out of space ends at decode. Free: decode, then a header check unless
//  the address is bad, then (header valid) a buddy read and merge per order
//  level until a merge fails or the pool order is reached, then the finish
//  steps. The controller goes back to idle before the next beat is taken.
//  Reset clears lists and control at once; no clearing pass.
//  A stalled result holds in the output register; the controller waits with
//  the next result until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int POOL_ORDER = POOL_ORDER_DEF,
    parameter int MIN_ORDER  = MIN_ORDER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,   // op
    input  wire logic [31:0] s_tdata,   // request_bytes, free_address
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_tuser,   // status
    output logic [15:0]      m_tdata    // payload_address
);

    dp_cmd_t     cmd;
    dp_stat_t    st;
    logic [1:0]  status;
    logic [15:0] payload_address;

    bba_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_status          (status),
        .m_payload_address (payload_address),
        .cmd               (cmd),
        .st                (st)
    );

    bba_dp #(
        .POOL_ORDER (POOL_ORDER),
        .MIN_ORDER  (MIN_ORDER)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_op            (s_tuser),
        .in_request_bytes (s_tdata[15:0]),
        .in_free_address  (s_tdata[31:16]),
        .st               (st)
    );

    assign m_tuser = status;
    assign m_tdata = payload_address;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for buddy_block_allocator: a short directed sequence,
// then random allocate/free traffic. Both sides idle at random. Every result
// beat is compared with the bench's own buddy allocator prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
    import bba_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL   = POOL_ORDER_DEF;
    localparam int GRAN   = MIN_ORDER_DEF;
    localparam int NBLK   = 1 << (POOL - GRAN);
    localparam int NLIST  = POOL + 1;
    localparam int N_RAND = 1900;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload;
    } alloc_res_t;

    class alloc_scoreboard;
        bit [4:0]    blk_ord[NBLK];
        bit          blk_free[NBLK];
        bit          hdr_set[NBLK];
        int unsigned nxt[NBLK];
        int unsigned prv[NBLK];
        int unsigned head[NLIST];
        int unsigned tail[NLIST];
        alloc_res_t  pending[$];
        int          errors;
        int          n_status[4];

        function new();
            for (int j = 0; j < NLIST; j++) begin
                head[j] = NBLK + j;
                tail[j] = NBLK + j;
            end
            head[POOL] = 0;
            tail[POOL] = 0;
            nxt[0] = NBLK + POOL;
            prv[0] = NBLK + POOL;
            blk_ord[0] = 5'(POOL);
            blk_free[0] = 1'b1;
            hdr_set[0] = 1'b1;
        endfunction

        function int unsigned link_next(int unsigned id);
            if (id < NBLK) return nxt[id];
            if (id < NBLK + NLIST) return head[id - NBLK];
            return 0;
        endfunction

        function void put_next(int unsigned id, int unsigned v);
            if (id < NBLK) nxt[id] = v;
            else if (id < NBLK + NLIST) head[id - NBLK] = v;
        endfunction

        function void put_prev(int unsigned id, int unsigned v);
            if (id < NBLK) prv[id] = v;
            else if (id < NBLK + NLIST) tail[id - NBLK] = v;
        endfunction

        function alloc_res_t take_block(bit [15:0] req);
            alloc_res_t  r;
            int unsigned sz, k, j, l, p, nx;
            r = '{status: RES_NO_SPACE, payload: 16'd0};
            sz = req + HDR_BYTES;
            k = GRAN;
            while (k <= POOL && sz > (1 << k)) k++;
            if (k > POOL) return r;
            j = k;
            while (j <= POOL && head[j] == NBLK + j) j++;
            if (j > POOL) return r;
            l = head[j];
            if (l >= NBLK) return r;
            nx = link_next(l);
            head[j] = nx;
            put_prev(nx, NBLK + j);
            blk_ord[l] = 5'(k);
            blk_free[l] = 1'b0;
            hdr_set[l] = 1'b1;
            // split down, parking each upper half on its own list
            while (j > k) begin
                j--;
                p = l + (1 << (j - GRAN));
                if (p >= NBLK) continue;
                blk_free[p] = 1'b1;
                blk_ord[p] = 5'(j);
                hdr_set[p] = 1'b1;
                nxt[p] = NBLK + j;
                prv[p] = NBLK + j;
                head[j] = p;
                tail[j] = p;
            end
            r.status = RES_ALLOCATED;
            r.payload = 16'((l << GRAN) + HDR_BYTES);
            return r;
        endfunction

        function logic [1:0] give_back(bit [15:0] addr);
            int unsigned off, l, k, p, pn, pp, hd;
            if (addr < HDR_BYTES) return RES_IGNORED;
            off = addr - HDR_BYTES;
            if ((off & ((1 << GRAN) - 1)) != 0) return RES_IGNORED;
            if ((off >> GRAN) >= NBLK) return RES_IGNORED;
            l = off >> GRAN;
            k = 32'(blk_ord[l]);
            if (k < GRAN || k > POOL) return RES_IGNORED;
            if (blk_free[l]) return RES_IGNORED;
            while (k < POOL) begin
                p = l ^ (1 << (k - GRAN));
                if (blk_ord[p] != k || !blk_free[p]) break;
                pn = nxt[p];
                pp = prv[p];
                put_next(pp, pn);
                put_prev(pn, pp);
                k++;
                if (p < l) l = p;
            end
            blk_free[l] = 1'b1;
            hd = head[k];
            nxt[l] = hd;
            put_prev(hd, l);
            prv[l] = NBLK + k;
            head[k] = l;
            blk_ord[l] = 5'(k);
            hdr_set[l] = 1'b1;
            return RES_FREED;
        endfunction

        function alloc_res_t note_request(bit op, bit [15:0] req, bit [15:0] addr);
            alloc_res_t r;
            if (op == OP_ALLOC) r = take_block(req);
            else r = '{status: give_back(addr), payload: 16'd0};
            pending.push_back(r);
            n_status[r.status]++;
            return r;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [1:0] u, logic [15:0] d);
            alloc_res_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result beat %h/%h", u, d));
                return;
            end
            e = pending.pop_front();
            if (u !== e.status)
                report($sformatf("status %0d, want %0d", u, e.status));
            if (d !== e.payload)
                report($sformatf("payload %h, want %h", d, e.payload));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [15:0] m_tdata;

    alloc_scoreboard sb = new();
    bit [15:0]       live[$];
    bit [15:0]       released[$];
    bit              quiet;
    bit              done_sending;

    always #6 aclk = ~aclk;

    buddy_block_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    task send_request(bit op, bit [15:0] req, bit [15:0] addr);
        int         gap;
        alloc_res_t r;
        gap = quiet ? 0 : $urandom_range(13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {addr, req};
        do @(posedge aclk); while (!s_tready);
        r = sb.note_request(op, req, addr);
        if (op == OP_ALLOC && r.status == RES_ALLOCATED) live.push_back(r.payload);
        if (op == OP_FREE && r.status == RES_FREED) released.push_back(addr);
        if (released.size() > 32) void'(released.pop_front());
    endtask

    // free a random live block, or (rarely) something that should be refused
    task pick_free(output bit [15:0] addr);
        int idx, g, sel;
        sel = $urandom_range(99);
        if (live.size() > 0 && sel < 85) begin
            idx = $urandom_range(live.size() - 1);
            addr = live[idx];
            live.delete(idx);
        end else if (sel < 90 && released.size() > 0) begin
            addr = released[$urandom_range(released.size() - 1)];
        end else if (sel < 95) begin
            // stale header: any granule whose header has been written
            g = $urandom_range(NBLK - 1);
            while (!sb.hdr_set[g]) g = (g + 1) % NBLK;
            addr = 16'((g << GRAN) + HDR_BYTES);
        end else if (sel < 97) begin
            addr = 16'($urandom_range(HDR_BYTES - 1));
        end else begin
            addr = 16'($urandom);
            if ((addr & 16'hf) == 16'h8) addr ^= 16'h1;
        end
    endtask

    initial begin
        bit [15:0] req, addr;
        bit        op;
        int        sel, t;
        quiet = 1'b0;
        done_sending = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, bad addresses, double free, whole pool, merges
        send_request(OP_FREE, 16'hffff, 16'd0);
        send_request(OP_FREE, 16'd0, 16'd9);
        send_request(OP_ALLOC, 16'd65535, 16'hffff);
        send_request(OP_ALLOC, 16'd65528, 16'd0);
        send_request(OP_ALLOC, 16'd0, 16'd0);
        send_request(OP_FREE, 16'd0, 16'd8);
        send_request(OP_FREE, 16'd0, 16'd8);
        send_request(OP_ALLOC, 16'd8, 16'd0);
        send_request(OP_ALLOC, 16'd9, 16'd0);
        send_request(OP_ALLOC, 16'd24, 16'd0);
        send_request(OP_ALLOC, 16'd32760, 16'd0);
        send_request(OP_ALLOC, 16'd1, 16'd0);
        send_request(OP_FREE, 16'd0, 16'd24);
        send_request(OP_FREE, 16'd0, 16'd8);
        send_request(OP_FREE, 16'd0, 16'd40);
        send_request(OP_FREE, 16'd0, 16'd72);
        send_request(OP_FREE, 16'd0, 16'd32776);
        send_request(OP_FREE, 16'd0, 16'd32776);
        send_request(OP_ALLOC, 16'd65529, 16'd0);
        live.delete();

        for (int i = 0; i < N_RAND; i++) begin
            if (i % 150 == 0) quiet = ($urandom_range(3) == 0);
            req = 16'($urandom);
            addr = 16'($urandom);
            sel = $urandom_range(99);
            op = (sel < 45) ? OP_FREE : OP_ALLOC;
            if (op == OP_FREE) pick_free(addr);
            else begin
                t = $urandom_range(99);
                if (t < 70) req = 16'($urandom_range(120));
                else if (t < 92) req = 16'($urandom_range(4000));
            end
            send_request(op, req, addr);
        end
        s_tvalid <= 1'b0;
        done_sending = 1'b1;
    end

    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    initial begin
        wait (done_sending);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Covered %0d allocations, %0d out of space, %0d frees, %0d refused frees.",
                 sb.n_status[RES_ALLOCATED], sb.n_status[RES_NO_SPACE],
                 sb.n_status[RES_FREED], sb.n_status[RES_IGNORED]);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for the block");
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/bba_pkg.sv
rtl/core/bba_dp.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator.sv
tb/tb.sv
